/* hw/rtl/rvct_pkg.sv */
`timescale 1ns / 1ps
package rvct_pkg;
  typedef enum logic [1:0] {
    CMD_VOTE    = 2'd0,
    CMD_TIMEOUT = 2'd1,
    CMD_TAKE    = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_ACCEPTED  = 3'd0,
    KIND_TIMEOUT   = 3'd1,
    KIND_FAILED    = 3'd2,
    KIND_COMPLETED = 3'd3,
    KIND_DONE      = 3'd4,
    KIND_BAD_RANK  = 3'd5,
    KIND_CHANGED   = 3'd6,
    KIND_FULL      = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_RESP,
    ST_SCAN,
    ST_DONE
  } state_t;

  localparam int unsigned CFG_REG_PCOUNT = 0;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch the request
    logic apply;     // lookup/update for vote or timeout, emit one result
    logic clear;     // free every entry, emit accepted
    logic scan_step; // handle entry at scan pointer
    logic emit_done; // emit scan-done result
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic out_busy;  // output register full and not taken
    logic scan_last; // scan pointer is at final entry
    logic scan_hold; // current entry needs another step
  } sts_t;
endpackage

/* hw/rtl/request_vote_consensus_table_core.sv */
`timescale 1ns / 1ps
// Vote table: each request collects one completed/failed vote per participant rank,
// keyed by a 64-bit id in TABLE_ENTRIES slots. One request is processed at a time.
// Vote, timeout and clear pass through capture, registered key match, then update and
// result. Take-ready walks every slot, one slot per cycle while the output register is
// not stalled, handling a slot with both a timeout report and a final verdict twice,
// then emits a done result. Results leave via a single output register; a new request
// waits until the last result has been loaded.
module request_vote_consensus_table_core import rvct_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES    = 16,
  parameter int unsigned MAX_PARTICIPANTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [63:0] request_id, [66:64] participant, [67] vote_failed
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] out_request_id
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [3:0] pcount_r;
  logic       in_fire;
  ctl_t       ctl;
  sts_t       sts;

  // participant_count register at byte address 0
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) pcount_r <= 4'd1;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
             && cfg_paddr == 2'(CFG_REG_PCOUNT * 4))
      pcount_r <= cfg_pwdata[3:0];
  end
  assign cfg_prdata = (cfg_paddr == 2'(CFG_REG_PCOUNT * 4)) ? {28'd0, pcount_r} : 32'd0;

  assign in_fire = in_tvalid && in_tready;

  rvct_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .sts, .ctl, .in_ready(in_tready)
  );

  rvct_dp #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_PARTICIPANTS(MAX_PARTICIPANTS)) u_dp (
    .clk, .rst_n, .ctl, .sts,
    .in_command(in_tuser), .in_request_id(in_tdata[63:0]),
    .in_participant(in_tdata[66:64]), .in_vote_failed(in_tdata[67]),
    .pcount(pcount_r),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_kind(out_tuser), .out_request_id(out_tdata), .out_last(out_tlast)
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.apply, ctl.clear, ctl.scan_step, ctl.emit_done}))
    else $error("multiple commands");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tuser) && $stable(out_tdata))
    else $error("result changed while stalled");
  a_fire_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("accepted back to back");
endmodule

/* hw/rtl/rvct_ctrl.sv */
`timescale 1ns / 1ps
module rvct_ctrl import rvct_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  sts_t sts,
  output ctl_t ctl,
  output logic in_ready
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_LOOKUP;
      ST_LOOKUP: begin
        if (sts.cmd == CMD_TAKE) state_nxt = ST_SCAN;
        else state_nxt = ST_RESP;
      end
      ST_RESP:   if (!sts.out_busy) state_nxt = ST_IDLE;
      ST_SCAN:   if (!sts.out_busy && sts.scan_last && !sts.scan_hold) state_nxt = ST_DONE;
      ST_DONE:   if (!sts.out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.capture = in_fire;
      end
      ST_LOOKUP: ;
      ST_RESP: begin
        if (!sts.out_busy) begin
          if (sts.cmd == CMD_CLEAR) ctl.clear = 1'b1;
          else ctl.apply = 1'b1;
        end
      end
      ST_SCAN: ctl.scan_step = !sts.out_busy;
      ST_DONE: ctl.emit_done = !sts.out_busy;
      default: ;
    endcase
  end
endmodule

/* hw/rtl/rvct_dp.sv */
`timescale 1ns / 1ps
module rvct_dp import rvct_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES    = 16,
  parameter int unsigned MAX_PARTICIPANTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctl_t        ctl,
  output sts_t        sts,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_request_id,
  input  logic [2:0]  in_participant,
  input  logic        in_vote_failed,
  input  logic [3:0]  pcount,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [63:0] out_request_id,
  output logic        out_last
);
  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_PARTICIPANTS + 1);
  localparam int unsigned MP = (MAX_PARTICIPANTS > 8) ? 8 : MAX_PARTICIPANTS;

  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [63:0]              key_r     [TABLE_ENTRIES];
  logic [MAX_PARTICIPANTS-1:0] voted_r [TABLE_ENTRIES];
  logic [MAX_PARTICIPANTS-1:0] fmask_r [TABLE_ENTRIES];
  logic [CW-1:0]            cnt_r     [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] anyf_r, tout_r, pend_r;

  cmd_t        cmd_r;
  logic [63:0] id_r;
  logic [2:0]  rank_r;
  logic        vote_r;
  logic [IW-1:0] ptr_r;
  logic        hit_r, free_ok_r;
  logic [IW-1:0] hit_idx_r, free_idx_r;

  logic        ov_r;
  logic [2:0]  okind_r;
  logic [63:0] oid_r;
  logic        olast_r;

  logic [CW-1:0] eff;
  always_comb begin
    if (pcount == 4'd0) eff = CW'(1);
    else if ({28'd0, pcount} > 32'(MP)) eff = CW'(MP);
    else eff = CW'(pcount);
  end

  // parallel key match and free search, registered
  logic hit_c, free_c;
  logic [IW-1:0] hit_i, free_i;
  always_comb begin
    hit_c = 1'b0; free_c = 1'b0; hit_i = '0; free_i = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && key_r[i] == id_r) begin
        hit_c = 1'b1; hit_i = IW'(i);
      end
      if (!valid_r[i]) begin
        free_c = 1'b1; free_i = IW'(i);
      end
    end
  end

  logic out_busy;
  assign out_busy = ov_r && !out_ready;

  logic cur_done;
  assign cur_done = valid_r[ptr_r] && cnt_r[ptr_r] == eff;
  assign sts.cmd = cmd_r;
  assign sts.out_busy = out_busy;
  assign sts.scan_last = (ptr_r == IW'(TABLE_ENTRIES - 1));
  assign sts.scan_hold = valid_r[ptr_r] && pend_r[ptr_r] && cnt_r[ptr_r] == eff;

  logic [IW-1:0] slot;
  logic [MAX_PARTICIPANTS-1:0] bit_m;
  assign slot  = hit_r ? hit_idx_r : free_idx_r;
  assign bit_m = MAX_PARTICIPANTS'(1) << rank_r;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r <= cmd_t'(in_command);
      id_r <= in_request_id;
      rank_r <= in_participant;
      vote_r <= in_vote_failed;
      ptr_r <= '0;
    end
    hit_r <= hit_c; free_ok_r <= free_c;
    hit_idx_r <= hit_i; free_idx_r <= free_i;

    if (ctl.apply && ({1'b0, rank_r} < 4'(eff) || cmd_r == CMD_TIMEOUT)
        && (hit_r || free_ok_r)) begin
      if (!hit_r) key_r[slot] <= id_r;
      if (cmd_r == CMD_TIMEOUT) begin
        if (!hit_r) begin
          voted_r[slot] <= '0; fmask_r[slot] <= '0; cnt_r[slot] <= '0;
          anyf_r[slot] <= 1'b0;
        end
        if (!hit_r || !tout_r[slot]) begin
          tout_r[slot] <= 1'b1; pend_r[slot] <= 1'b1;
        end
      end else begin
        if (!hit_r) begin
          tout_r[slot] <= 1'b0; pend_r[slot] <= 1'b0;
        end
        if (!hit_r || !(|(voted_r[slot] & bit_m))) begin
          voted_r[slot] <= (hit_r ? voted_r[slot] : '0) | bit_m;
          fmask_r[slot] <= (hit_r ? fmask_r[slot] : '0) | (vote_r ? bit_m : '0);
          anyf_r[slot] <= (hit_r ? anyf_r[slot] : 1'b0) | vote_r;
          cnt_r[slot] <= (hit_r ? cnt_r[slot] : '0) + CW'(1);
        end
      end
    end
    if (ctl.scan_step) begin
      if (valid_r[ptr_r] && pend_r[ptr_r]) pend_r[ptr_r] <= 1'b0;
      if (!sts.scan_hold && !sts.scan_last) ptr_r <= ptr_r + IW'(1);
    end
  end

  // entry valid bits
  always_comb begin
    valid_nxt = valid_r;
    if (ctl.clear) valid_nxt = '0;
    if (ctl.apply && ({1'b0, rank_r} < 4'(eff) || cmd_r == CMD_TIMEOUT)
        && !hit_r && free_ok_r) valid_nxt[free_idx_r] = 1'b1;
    if (ctl.scan_step && cur_done && !pend_r[ptr_r]) valid_nxt[ptr_r] = 1'b0;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= '0;
    else valid_r <= valid_nxt;
  end

  // output register
  logic       emit;
  logic [2:0] kind_c;
  logic [63:0] oid_c;
  always_comb begin
    emit = 1'b0; kind_c = KIND_ACCEPTED; oid_c = '0;
    if (ctl.clear) emit = 1'b1;
    else if (ctl.emit_done) begin
      emit = 1'b1; kind_c = KIND_DONE;
    end else if (ctl.apply) begin
      emit = 1'b1;
      if (cmd_r == CMD_VOTE && !({1'b0, rank_r} < 4'(eff))) kind_c = KIND_BAD_RANK;
      else if (!hit_r && !free_ok_r) kind_c = KIND_FULL;
      else if (cmd_r == CMD_VOTE && hit_r && |(voted_r[slot] & bit_m)
               && (|(fmask_r[slot] & bit_m)) != vote_r) kind_c = KIND_CHANGED;
    end else if (ctl.scan_step && valid_r[ptr_r]) begin
      if (pend_r[ptr_r]) begin
        emit = 1'b1; kind_c = KIND_TIMEOUT; oid_c = key_r[ptr_r];
      end else if (cur_done) begin
        emit = 1'b1; oid_c = key_r[ptr_r];
        kind_c = (anyf_r[ptr_r] || tout_r[ptr_r]) ? KIND_FAILED : KIND_COMPLETED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (emit) ov_r <= 1'b1;
    else if (out_ready) ov_r <= 1'b0;
    if (emit) begin
      okind_r <= kind_c; oid_r <= oid_c;
      olast_r <= ctl.clear || ctl.emit_done || ctl.apply;
    end
  end

  assign out_valid = ov_r;
  assign out_kind = okind_r;
  assign out_request_id = oid_r;
  assign out_last = olast_r;
endmodule
